// File: sv/tdpt_pkg.sv
// Shared types, micro-op codes and the microcode table of the trial division prime tester.
package tdpt_pkg;

    // Datapath micro-ops
    typedef enum logic [2:0] {
        OP_NOP,
        OP_INIT,
        OP_REM_START,
        OP_REM_STEP,
        OP_NEXT_D,
        OP_PASS,
        OP_EMIT
    } uop_t;

    // Branch conditions
    typedef enum logic [2:0] {
        CND_ITEM,
        CND_SMALL,
        CND_SQ_GT,
        CND_CNT_LAST,
        CND_REM_ZERO,
        CND_PHASE1,
        CND_OUT_FREE
    } cond_t;

    typedef logic [2:0] upc_t;

    localparam upc_t STEP_WAIT = 3'd0;
    localparam upc_t STEP_INIT = 3'd1;
    localparam upc_t STEP_TRY  = 3'd2;
    localparam upc_t STEP_DIV  = 3'd3;
    localparam upc_t STEP_NEXT = 3'd4;
    localparam upc_t STEP_PASS = 3'd5;
    localparam upc_t STEP_DONE = 3'd6;

    // Go to jump when cond holds, else to next
    typedef struct packed {
        uop_t  op;
        cond_t cond;
        upc_t  jump;
        upc_t  next;
    } uword_t;

    typedef struct packed {
        logic le_one;
        logic sq_gt;
        logic cnt_last;
        logic rem_zero;
        logic phase1;
        logic prime;
        logic twin;
    } dp_status_t;

    function automatic uword_t ucode_rom(input upc_t addr);
        uword_t w;
        case (addr)
            STEP_WAIT: w = '{OP_NOP,       CND_ITEM,     STEP_INIT, STEP_WAIT};
            STEP_INIT: w = '{OP_INIT,      CND_SMALL,    STEP_DONE, STEP_TRY};
            STEP_TRY:  w = '{OP_REM_START, CND_SQ_GT,    STEP_PASS, STEP_DIV};
            STEP_DIV:  w = '{OP_REM_STEP,  CND_CNT_LAST, STEP_NEXT, STEP_DIV};
            STEP_NEXT: w = '{OP_NEXT_D,    CND_REM_ZERO, STEP_DONE, STEP_TRY};
            STEP_PASS: w = '{OP_PASS,      CND_PHASE1,   STEP_DONE, STEP_INIT};
            STEP_DONE: w = '{OP_EMIT,      CND_OUT_FREE, STEP_WAIT, STEP_DONE};
            default:   w = '{OP_NOP,       CND_ITEM,     STEP_WAIT, STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// File: sv/tdpt_datapath.sv
// Datapath: candidate, trial divisor, its square and a bit-serial remainder unit.
module tdpt_datapath #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    load,
    input  logic [NUMBER_WIDTH-1:0] number,
    input  tdpt_pkg::uop_t          op,
    output tdpt_pkg::dp_status_t    status
);
    import tdpt_pkg::*;

    localparam int CANDW = NUMBER_WIDTH + 1;      // n + 2 never wraps
    localparam int DW    = NUMBER_WIDTH / 2 + 2;  // divisor stays near sqrt
    localparam int SW    = NUMBER_WIDTH + 2;      // square of divisor
    localparam int CW    = $clog2(NUMBER_WIDTH + 2);

    logic [CANDW-1:0] cand_reg;
    logic [CANDW-1:0] sh_reg;
    logic [DW-1:0]    d_reg;
    logic [SW-1:0]    sq_reg;
    logic [DW-1:0]    rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             phase_reg;
    logic             prime_reg;
    logic             twin_reg;

    logic [DW:0]      rem_shift;
    logic [DW:0]      rem_sub;
    logic [DW-1:0]    rem_next;

    // One restoring division step per cycle
    always_comb begin
        rem_shift = {rem_reg, sh_reg[CANDW-1]};
        rem_sub   = rem_shift - {1'b0, d_reg};
        rem_next  = (rem_shift >= {1'b0, d_reg}) ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cand_reg  <= {1'b0, number};
            phase_reg <= 1'b0;
            prime_reg <= 1'b0;
            twin_reg  <= 1'b0;
        end else begin
            case (op)
                OP_INIT: begin
                    d_reg  <= DW'(2);
                    sq_reg <= SW'(4);
                end
                OP_REM_START: begin
                    sh_reg  <= cand_reg;
                    rem_reg <= '0;
                    cnt_reg <= CW'(CANDW);
                end
                OP_REM_STEP: begin
                    sh_reg  <= {sh_reg[CANDW-2:0], 1'b0};
                    rem_reg <= rem_next;
                    cnt_reg <= cnt_reg - CW'(1);
                end
                OP_NEXT_D: begin
                    // (d+1)^2 = d^2 + 2d + 1
                    sq_reg <= sq_reg + SW'({d_reg, 1'b0}) + SW'(1);
                    d_reg  <= d_reg + DW'(1);
                end
                OP_PASS: begin
                    if (phase_reg) begin
                        twin_reg <= 1'b1;
                    end else begin
                        prime_reg <= 1'b1;
                        phase_reg <= 1'b1;
                        cand_reg  <= cand_reg + CANDW'(2);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        status.le_one   = cand_reg <= CANDW'(1);
        status.sq_gt    = sq_reg > SW'(cand_reg);
        status.cnt_last = cnt_reg == CW'(1);
        status.rem_zero = rem_reg == '0;
        status.phase1   = phase_reg;
        status.prime    = prime_reg;
        status.twin     = twin_reg;
    end

endmodule

// File: sv/trial_division_prime_test.sv
// Top level: microcode sequencer, handshakes and result register of the prime tester.
//
//  channel | ports                               | role
//  --------+-------------------------------------+------------------------------
//  s_      | s_valid, s_ready, s_number          | candidate in, one item at a time
//  m_      | m_valid, m_ready, m_is_prime,       | primality and twin flag out
//          | m_twin_lower                        |
//
// For each trial divisor the remainder unit shifts one candidate bit per cycle over
// NUMBER_WIDTH + 1 bits. Divisors from 2 up to floor(sqrt(n)) are tried for n until one
// divides it, and the same again for n + 2 when n is prime.
// s_ready is high only while the sequencer waits for an item; a result waiting in the
// output register does not stop the next item from being taken. Reset is synchronous.
module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [NUMBER_WIDTH-1:0] s_number,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_is_prime,
    output logic                    m_twin_lower
);
    import tdpt_pkg::*;

    upc_t       upc_reg;
    upc_t       upc_next;
    uword_t     uword;
    dp_status_t status;
    logic       cond_hit;
    logic       s_fire;
    logic       out_free;

    logic       m_valid_reg;
    logic       m_is_prime_reg;
    logic       m_twin_lower_reg;

    assign uword    = ucode_rom(upc_reg);
    assign s_ready  = upc_reg == STEP_WAIT;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (uword.cond)
            CND_ITEM:     cond_hit = s_fire;
            CND_SMALL:    cond_hit = status.le_one;
            CND_SQ_GT:    cond_hit = status.sq_gt;
            CND_CNT_LAST: cond_hit = status.cnt_last;
            CND_REM_ZERO: cond_hit = status.rem_zero;
            CND_PHASE1:   cond_hit = status.phase1;
            CND_OUT_FREE: cond_hit = out_free;
            default:      cond_hit = 1'b0;
        endcase
        upc_next = cond_hit ? uword.jump : uword.next;
    end

    tdpt_datapath #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) u_datapath (
        .aclk   (aclk),
        .load   (s_fire),
        .number (s_number),
        .op     (uword.op),
        .status (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= STEP_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            if (uword.op == OP_EMIT && out_free) begin
                m_valid_reg      <= 1'b1;
                m_is_prime_reg   <= status.prime;
                m_twin_lower_reg <= status.twin;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_is_prime   = m_is_prime_reg;
    assign m_twin_lower = m_twin_lower_reg;

endmodule

// File: tb/tb.sv
// Testbench for trial_division_prime_test: directed and random numbers against a predictor.
module tb;

    localparam int NW           = 16;
    localparam int IDLE_LIMIT   = 60000;
    localparam int DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [NW-1:0] number;
        logic          is_prime;
        logic          twin_lower;
    } prime_verdict_t;

    logic          aclk         = 1'b0;
    logic          aresetn      = 1'b0;
    logic          s_valid      = 1'b0;
    logic          s_ready;
    logic [NW-1:0] s_number     = '0;
    logic          m_valid;
    logic          m_ready      = 1'b0;
    logic          m_is_prime;
    logic          m_twin_lower;

    prime_verdict_t verdict_q[$];
    int             error_count = 0;
    int             stall_count = 0;
    int             s_idle_pct  = 0;
    int             m_idle_pct  = 0;

    trial_division_prime_test #(
        .NUMBER_WIDTH(NW)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number     (s_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_prime   (m_is_prime),
        .m_twin_lower (m_twin_lower)
    );

    always #5 aclk = ~aclk;

    // Candidate is tested one bit wider so n + 2 never wraps
    function automatic bit trial_prime(input logic [NW:0] n);
        longint unsigned d;
        longint unsigned v;
        v = n;
        if (v <= 1)
            return 1'b0;
        for (d = 2; d * d <= v; d++)
            if (v % d == 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic prime_verdict_t predict_verdict(input logic [NW-1:0] n);
        prime_verdict_t v;
        v.number     = n;
        v.is_prime   = trial_prime({1'b0, n});
        v.twin_lower = v.is_prime && trial_prime({1'b0, n} + (NW+1)'(2));
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Drives one item; s_valid stays high across back-to-back items
    task automatic send_number(input logic [NW-1:0] n);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < s_idle_pct)
                @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_number <= n;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        verdict_q.push_back(predict_verdict(n));
    endtask

    // Result checker and receiver back-pressure
    always @(posedge aclk) begin
        prime_verdict_t want;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result is_prime=%0b twin_lower=%0b",
                                          m_is_prime, m_twin_lower));
            end else begin
                want = verdict_q.pop_front();
                if (m_is_prime !== want.is_prime)
                    report_mismatch($sformatf("n=%0d is_prime got %0b want %0b",
                                              want.number, m_is_prime, want.is_prime));
                if (m_twin_lower !== want.twin_lower)
                    report_mismatch($sformatf("n=%0d twin_lower got %0b want %0b",
                                              want.number, m_twin_lower, want.twin_lower));
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Watchdog: cycles with no item moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic test_edge_values();
        send_number(16'd0);
        send_number(16'd1);
        send_number(16'd2);
        send_number(16'd4);
        send_number(16'h8000);
        send_number(16'h5555);
        send_number(16'hAAAA);
        send_number(16'd65533);
        send_number(16'd65534);  // n + 2 lands at the 17th bit
        send_number(16'd65535);
    endtask

    task automatic test_twins_and_squares();
        send_number(16'd3);
        send_number(16'd5);
        send_number(16'd7);
        send_number(16'd9);
        send_number(16'd11);
        send_number(16'd17);
        send_number(16'd29);
        send_number(16'd25);
        send_number(16'd49);
        send_number(16'd32761);  // 181^2
        send_number(16'd63001);  // 251^2, divisor bound exactly at sqrt
        send_number(16'd65025);  // 255^2
        send_number(16'd65519);
        send_number(16'd65521);
    endtask

    // Mostly small candidates to keep the run short; a few full-range and large primes
    task automatic test_random_mix(input int count, input int s_pct, input int m_pct);
        int             r;
        logic [NW-1:0]  n;
        prime_verdict_t pv;
        s_idle_pct = s_pct;
        m_idle_pct = m_pct;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 42) begin
                n = NW'($urandom_range(1023));
            end else if (r < 57) begin
                do n = NW'($urandom_range(1023, 2)); while (!trial_prime({1'b0, n}));
            end else if (r < 72) begin
                do begin
                    n  = NW'($urandom_range(1023, 2));
                    pv = predict_verdict(n);
                end while (!pv.twin_lower);
            end else if (r < 84) begin
                n = NW'($urandom_range(16383));
            end else if (r < 97) begin
                n = NW'($urandom);
            end else begin
                do n = NW'($urandom_range(65535, 49152)); while (!trial_prime({1'b0, n}));
            end
            send_number(n);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        s_idle_pct = 11;
        m_idle_pct = 51;
        test_edge_values();
        test_twins_and_squares();
        test_random_mix(300, 11, 51);
        test_random_mix(300, 51, 11);
        test_random_mix(300, 0, 0);

        s_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
